>>> hdl/thfs_pkg.sv
// ----------------------------------------------------------------------------
// thfs_pkg
// shared types, constants, fade rom and pattern functions of the turn / hazard flasher
// ----------------------------------------------------------------------------
package thfs_pkg;

	localparam int PATTERN_STEPS = 100;
	localparam int ROM_LEN       = 100;
	localparam int FRAME_W       = 7;
	localparam int COUNT_W       = 8;
	localparam int DUTY_W        = 7;

	localparam logic [FRAME_W:0]   STEPS_LIMIT      = (FRAME_W + 1)'(PATTERN_STEPS);
	localparam logic [FRAME_W-1:0] ROM_LAST         = FRAME_W'(ROM_LEN - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'hFF;
	localparam logic [7:0]         AUTO_FLASH_RESET = 8'd5;

	// register byte offsets (word aligned)
	localparam logic [2:0] REG_AUTO_FLASH = 3'd0;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_HAZARD = 2'd1,
		MODE_RIGHT  = 2'd2,
		MODE_LEFT   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                mode;
		logic [FRAME_W-1:0]   frame;
		logic [COUNT_W-1:0]   count;
		logic [DUTY_W-1:0]    duty;
	} seq_state_t;

	typedef struct packed {
		logic position_allowed;
		logic illumination_on;
		logic left_switch;
		logic right_switch;
		logic hazard_switch;
	} switch_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_percent;
		logic              flash_enable;
		logic              left_position_enable;
		logic              right_position_enable;
		logic              left_lamp_enable;
		logic              right_lamp_enable;
	} lamp_word_t;

	localparam logic [DUTY_W-1:0] FADE_ROM [ROM_LEN] = '{
		7'd100, 7'd98, 7'd96, 7'd94, 7'd91, 7'd89, 7'd87, 7'd85, 7'd83, 7'd81,
		7'd79,  7'd77, 7'd75, 7'd74, 7'd72, 7'd70, 7'd68, 7'd66, 7'd65, 7'd63,
		7'd61,  7'd60, 7'd58, 7'd56, 7'd55, 7'd53, 7'd52, 7'd50, 7'd49, 7'd47,
		7'd46,  7'd44, 7'd43, 7'd41, 7'd40, 7'd39, 7'd37, 7'd36, 7'd35, 7'd34,
		7'd33,  7'd31, 7'd30, 7'd29, 7'd28, 7'd27, 7'd26, 7'd25, 7'd24, 7'd23,
		7'd22,  7'd21, 7'd20, 7'd19, 7'd18, 7'd17, 7'd16, 7'd16, 7'd15, 7'd14,
		7'd13,  7'd13, 7'd12, 7'd11, 7'd11, 7'd10, 7'd9,  7'd9,  7'd8,  7'd8,
		7'd7,   7'd7,  7'd6,  7'd6,  7'd5,  7'd5,  7'd4,  7'd4,  7'd4,  7'd3,
		7'd3,   7'd3,  7'd2,  7'd2,  7'd2,  7'd2,  7'd1,  7'd1,  7'd1,  7'd1,
		7'd1,   7'd1,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
	};

	// fade curve, zero past the end of the table
	function automatic logic [DUTY_W-1:0] fade_duty(input logic [FRAME_W-1:0] idx);
		logic [DUTY_W-1:0] d;
		d = '0;
		if (idx <= ROM_LAST) begin
			d = FADE_ROM[idx];
		end
		return d;
	endfunction

	// three hard on/off blinks of twelve frames each
	function automatic logic [DUTY_W-1:0] onoff_duty(input logic [FRAME_W-1:0] idx);
		logic on;
		on = (idx <= 7'd11) ||
			(idx >= 7'd24 && idx <= 7'd35) ||
			(idx >= 7'd48 && idx <= 7'd59);
		return on ? 7'd100 : 7'd0;
	endfunction

endpackage

>>> hdl/turn_hazard_flasher_sequencer.sv
// ----------------------------------------------------------------------------
// turn_hazard_flasher_sequencer
// frame-tick driven turn signal and hazard flasher with fade duty output
// ----------------------------------------------------------------------------
// an accepted word passes the input register, then the output register, to the master side
// throughput: one word per cycle while m_tready holds; the frame step is a single pass
//   of logic between the input register and the output register
// a full output register that m_tready does not take stalls the input register, then the slave side
// reset: async, active low; mode idle, counters and held duty zero,
//   auto flash limit 5
module turn_hazard_flasher_sequencer import thfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// slave side, s_tdata: hazard_switch, right_switch, left_switch,
	// illumination_on, position_allowed, three zero bits
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// master side, m_tdata: right_lamp_enable, left_lamp_enable,
	// right_position_enable, left_position_enable, flash_enable,
	// duty_percent[6:0], four zero bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// input register
	logic         valid_s1;
	switch_word_t sw_s1;

	// sequencer state and limit register
	seq_state_t   state_q;
	seq_state_t   state_nxt;
	logic [7:0]   auto_flash_q;

	// output register
	logic         out_valid_q;
	lamp_word_t   out_q;
	lamp_word_t   lamps;

	logic         advance;

	// the frame step commits when the output register can take its word
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sw_s1 <= switch_word_t'(s_tdata[4:0]);
		end
	end

	thfs_step u_step (
		.cur               (state_q),
		.sw                (sw_s1),
		.auto_flash_cycles (auto_flash_q),
		.nxt               (state_nxt),
		.lamps             (lamps)
	);

	// state register, moves once per frame tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= MODE_IDLE;
			state_q.frame <= '0;
			state_q.count <= '0;
			state_q.duty  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= lamps;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q};

	// config: one register, word aligned, pready tied high
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_flash_q <= AUTO_FLASH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_AUTO_FLASH[2]) begin
			auto_flash_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_AUTO_FLASH[2]) ? {24'd0, auto_flash_q} : 32'd0;

	// frame index never leaves the pattern
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, state_q.frame} < STEPS_LIMIT)
		else $error("frame index beyond pattern length");

	// idle state only after a pattern end or an idle tick
	a_idle_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_IDLE |-> (state_q.frame == 7'd0 || state_q.frame == 7'd1))
		else $error("idle with frame index in mid cycle");

	// state moves only when a frame tick commits
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state changed without a frame tick");

	// no flashing lamp without flash enable
	a_lamp_flash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.flash_enable |->
			!out_q.right_lamp_enable && !out_q.left_lamp_enable)
		else $error("lamp enabled while not flashing");

endmodule

>>> hdl/thfs_step.sv
// ----------------------------------------------------------------------------
// thfs_step
// one frame tick: mode latch, lamp decode, duty lookup and counter update
// ----------------------------------------------------------------------------
module thfs_step import thfs_pkg::*; (
	input  seq_state_t   cur,
	input  switch_word_t sw,
	input  logic [7:0]   auto_flash_cycles,
	output seq_state_t   nxt,
	output lamp_word_t   lamps
);

	mode_t              mode1;
	logic [FRAME_W-1:0] frame1;
	logic [COUNT_W-1:0] count1;
	logic [COUNT_W-1:0] count_inc;
	logic [FRAME_W:0]   frame_inc;
	logic               pos;
	logic [DUTY_W-1:0]  duty;
	logic               is_turn;

	assign pos = sw.illumination_on & sw.position_allowed;

	// latch a mode from the switches when idle
	always_comb begin
		mode1 = cur.mode;
		if (cur.mode == MODE_IDLE) begin
			priority if (sw.hazard_switch) mode1 = MODE_HAZARD;
			else if (sw.right_switch)      mode1 = MODE_RIGHT;
			else if (sw.left_switch)       mode1 = MODE_LEFT;
			else                           mode1 = MODE_IDLE;
		end
	end

	assign frame1 = (mode1 == MODE_IDLE) ? '0 : cur.frame;
	assign count1 = (mode1 == MODE_IDLE) ? '0 : cur.count;

	always_comb begin
		lamps = '0;
		unique case (mode1)
			MODE_HAZARD: begin
				lamps.right_lamp_enable = 1'b1;
				lamps.left_lamp_enable  = 1'b1;
			end
			MODE_RIGHT: begin
				lamps.right_lamp_enable    = 1'b1;
				lamps.left_position_enable = pos;
			end
			MODE_LEFT: begin
				lamps.left_lamp_enable      = 1'b1;
				lamps.right_position_enable = pos;
			end
			MODE_IDLE: begin
				lamps.right_position_enable = pos;
				lamps.left_position_enable  = pos;
			end
		endcase
		lamps.flash_enable = (mode1 != MODE_IDLE);
		lamps.duty_percent = duty;
	end

	// first hazard cycle blinks hard, other active cycles fade, idle holds the duty
	always_comb begin
		priority if (mode1 == MODE_HAZARD && count1 == '0) duty = onoff_duty(frame1);
		else if (mode1 != MODE_IDLE)                       duty = fade_duty(frame1);
		else                                               duty = cur.duty;
	end

	assign frame_inc = {1'b0, frame1} + 1'b1;
	assign count_inc = count1 + 1'b1;
	assign is_turn   = (mode1 == MODE_RIGHT) || (mode1 == MODE_LEFT);

	always_comb begin
		nxt.duty  = duty;
		nxt.mode  = mode1;
		nxt.count = count1;
		nxt.frame = frame_inc[FRAME_W-1:0];
		if (frame_inc >= STEPS_LIMIT) begin
			nxt.frame = '0;
			nxt.mode  = MODE_IDLE;
			if (count1 != COUNT_MAX) begin
				nxt.count = count_inc;
				if (is_turn && count_inc < auto_flash_cycles) begin
					nxt.mode = mode1;
				end
			end
		end
	end

endmodule
